// ----- rtl/lgst_pkg.sv -----
// -----------------------------------------------------------------------------
// lgst_pkg: shared definitions for the toroidal Game of Life row engine
// Sizes, register codes and rule constants used by the core and its channels.
// -----------------------------------------------------------------------------
`default_nettype none

package lgst_pkg;

	// Default number of cell columns a row can hold.
	localparam int MAX_COLUMNS_DEF = 64;

	// Configuration register widths and reset values.
	localparam int ROW_WIDTH_BITS = 7;
	localparam int ROW_COUNT_BITS = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;
	localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 7'd64;
	localparam logic [ROW_COUNT_BITS-1:0] ROW_COUNT_RESET = 16'd64;

	// Smallest usable width or height of the grid.
	localparam int MIN_SIZE = 3;

	// Rule B3/S23: a cell is born on three neighbors and survives on two or three.
	localparam int BORN_COUNT    = 3;
	localparam int SURVIVE_COUNT = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ROW_WIDTH = 1'b0,
		REG_ROW_COUNT = 1'b1
	} cfg_reg_t;

	// How many results one accepted row produces.
	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_ONE   = 2'd1,
		KIND_THREE = 2'd2
	} kind_t;

	// Position of a result inside the group emitted for one row.
	localparam logic [1:0] SEL_FIRST = 2'd0;
	localparam logic [1:0] SEL_MID   = 2'd1;
	localparam logic [1:0] SEL_LAST  = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/lgst_in_if.sv -----
// -----------------------------------------------------------------------------
// lgst_in_if: input row channel
// Valid/ready channel that carries one row of the current generation.
// -----------------------------------------------------------------------------
`default_nettype none

interface lgst_in_if #(
	parameter int COLS = lgst_pkg::MAX_COLUMNS_DEF
);
	logic            valid;
	logic            ready;
	logic [COLS-1:0] cell_row;

	modport source (output valid, output cell_row, input ready);
	modport sink   (input valid, input cell_row, output ready);
endinterface

`default_nettype wire

// ----- rtl/lgst_out_if.sv -----
// -----------------------------------------------------------------------------
// lgst_out_if: result row channel
// Valid/ready channel that carries one next-generation row and its index.
// -----------------------------------------------------------------------------
`default_nettype none

interface lgst_out_if #(
	parameter int COLS = lgst_pkg::MAX_COLUMNS_DEF
);
	logic                                valid;
	logic                                ready;
	logic [COLS-1:0]                     next_row;
	logic [lgst_pkg::ROW_COUNT_BITS-1:0] row_index;
	logic                                frame_done;

	modport source (output valid, output next_row, output row_index, output frame_done,
		input ready);
	modport sink   (input valid, input next_row, input row_index, input frame_done,
		output ready);
endinterface

`default_nettype wire

// ----- rtl/life_generation_step_torus_core.sv -----
// A row that completes a result is registered in the input stage, then in the result stage, where it is shown.
// Rows are taken one per cycle while in_ch.ready is high, which stalls when the result stage cannot drain;
// the last row of a frame yields three results, which leave the result stage one per output handshake.
// The three result rows of each item are computed in parallel between the input and result stages.
// Reset (arst_n low) empties both stages, restarts the frame at row 0 and sets
// row_width and row_count to 64.
// -----------------------------------------------------------------------------
// life_generation_step_torus_core: one Game of Life generation on a torus
// Rows stream in top to bottom; next-generation rows stream out with their index.
// -----------------------------------------------------------------------------
`default_nettype none

module life_generation_step_torus_core #(
	parameter int MAX_COLUMNS = lgst_pkg::MAX_COLUMNS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [lgst_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [lgst_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	lgst_in_if.sink                                  in_ch,
	lgst_out_if.source                               out_ch
);

	localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RW = lgst_pkg::ROW_WIDTH_BITS;
	localparam int RC = lgst_pkg::ROW_COUNT_BITS;

	// Next generation of the middle row, with wrap at column wm1.
	function automatic logic [MAX_COLUMNS-1:0] next_gen(
		input logic [MAX_COLUMNS-1:0] up,
		input logic [MAX_COLUMNS-1:0] mid,
		input logic [MAX_COLUMNS-1:0] dn,
		input logic [IW-1:0]          wm1
	);
		logic [MAX_COLUMNS-1:0] res;
		logic [3:0]             n;
		int                     xl;
		int                     xr;
		res = '0;
		for (int x = 0; x < MAX_COLUMNS; x++) begin
			xl = (x == 0) ? int'(wm1) : x - 1;
			xr = (x == int'(wm1) || x == MAX_COLUMNS - 1) ? 0 : x + 1;
			n = 4'(up[xl]) + 4'(up[x]) + 4'(up[xr]) + 4'(mid[xl]) + 4'(mid[xr])
				+ 4'(dn[xl]) + 4'(dn[x]) + 4'(dn[xr]);
			res[x] = (x <= int'(wm1)) && ((n == 4'(lgst_pkg::BORN_COUNT))
				|| (mid[x] && n == 4'(lgst_pkg::SURVIVE_COUNT)));
		end
		return res;
	endfunction

	// Configuration registers.
	logic [RW-1:0] row_width_q;
	logic [RC-1:0] row_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= lgst_pkg::ROW_WIDTH_RESET;
			row_count_q <= lgst_pkg::ROW_COUNT_RESET;
		end else if (cfg_wr_en) begin
			case (lgst_pkg::cfg_reg_t'(cfg_index))
				lgst_pkg::REG_ROW_WIDTH: row_width_q <= cfg_data[RW-1:0];
				lgst_pkg::REG_ROW_COUNT: row_count_q <= cfg_data[RC-1:0];
				default: ;
			endcase
		end
	end

	// Effective sizes: width clamped to [3, MAX_COLUMNS], height at least 3.
	logic [IW-1:0] wm1;
	logic [RC-1:0] height;
	logic [RC-1:0] row_counter_q;
	logic          is_last;
	logic [RC-1:0] idx0;

	always_comb begin
		if (row_width_q < RW'(lgst_pkg::MIN_SIZE)) begin
			wm1 = IW'(lgst_pkg::MIN_SIZE - 1);
		end else if (row_width_q > RW'(MAX_COLUMNS)) begin
			wm1 = IW'(MAX_COLUMNS - 1);
		end else begin
			wm1 = IW'(row_width_q - RW'(1));
		end
		height = (row_count_q < RC'(lgst_pkg::MIN_SIZE)) ? RC'(lgst_pkg::MIN_SIZE)
			: row_count_q;
		is_last = row_counter_q >= height - RC'(1);
		idx0 = is_last ? height - RC'(2) : row_counter_q - RC'(1);
	end

	// Incoming row with the columns past the width cleared.
	logic [MAX_COLUMNS-1:0] cur_row;

	always_comb begin
		for (int x = 0; x < MAX_COLUMNS; x++) begin
			cur_row[x] = in_ch.cell_row[x] && (x <= int'(wm1));
		end
	end

	// Handshake between the input stage, the result stage and the channels.
	logic           valid_s1;
	logic           valid_s2;
	logic [1:0]     sel_q;
	logic [1:0]     last_sel_s2;
	logic           s2_free;
	logic           in_acc;
	logic           out_acc;
	lgst_pkg::kind_t kind_s1;

	assign out_acc      = out_ch.valid && out_ch.ready;
	assign s2_free      = !valid_s2 || (out_ch.ready && sel_q == last_sel_s2);
	assign in_ch.ready  = !valid_s1 || s2_free;
	assign in_acc       = in_ch.valid && in_ch.ready;

	// Frame state: stored rows and the index of the next row expected.
	logic [MAX_COLUMNS-1:0] first_row_q;
	logic [MAX_COLUMNS-1:0] second_row_q;
	logic [MAX_COLUMNS-1:0] older_row_q;
	logic [MAX_COLUMNS-1:0] newer_row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_counter_q <= '0;
		end else if (in_acc) begin
			row_counter_q <= is_last ? '0 : row_counter_q + RC'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (!is_last && row_counter_q == RC'(0)) begin
				first_row_q <= cur_row;
			end
			if (!is_last && row_counter_q == RC'(1)) begin
				second_row_q <= cur_row;
			end
			older_row_q <= newer_row_q;
			newer_row_q <= cur_row;
		end
	end

	// Input stage: the rows that the results of this item need.
	logic [MAX_COLUMNS-1:0] older_s1;
	logic [MAX_COLUMNS-1:0] newer_s1;
	logic [MAX_COLUMNS-1:0] cur_s1;
	logic [MAX_COLUMNS-1:0] first_s1;
	logic [MAX_COLUMNS-1:0] second_s1;
	logic [IW-1:0]          wm1_s1;
	logic [RC-1:0]          idx0_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			older_s1  <= older_row_q;
			newer_s1  <= newer_row_q;
			cur_s1    <= cur_row;
			first_s1  <= first_row_q;
			second_s1 <= second_row_q;
			wm1_s1    <= wm1;
			idx0_s1   <= idx0;
			if (is_last) begin
				kind_s1 <= lgst_pkg::KIND_THREE;
			end else if (row_counter_q < RC'(2)) begin
				kind_s1 <= lgst_pkg::KIND_NONE;
			end else begin
				kind_s1 <= lgst_pkg::KIND_ONE;
			end
		end
	end

	// Result stage: up to three finished rows, emitted one per handshake.
	logic [MAX_COLUMNS-1:0] gen0_s2;
	logic [MAX_COLUMNS-1:0] gen1_s2;
	logic [MAX_COLUMNS-1:0] gen2_s2;
	logic [RC-1:0]          idx0_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			sel_q    <= lgst_pkg::SEL_FIRST;
		end else if (s2_free) begin
			valid_s2 <= valid_s1 && kind_s1 != lgst_pkg::KIND_NONE;
			sel_q    <= lgst_pkg::SEL_FIRST;
		end else if (out_acc) begin
			sel_q <= sel_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			gen0_s2     <= next_gen(older_s1, newer_s1, cur_s1, wm1_s1);
			gen1_s2     <= next_gen(newer_s1, cur_s1, first_s1, wm1_s1);
			gen2_s2     <= next_gen(cur_s1, first_s1, second_s1, wm1_s1);
			idx0_s2     <= idx0_s1;
			last_sel_s2 <= (kind_s1 == lgst_pkg::KIND_THREE) ? lgst_pkg::SEL_LAST
				: lgst_pkg::SEL_FIRST;
		end
	end

	// Output selection within the group.
	assign out_ch.valid = valid_s2;

	always_comb begin
		case (sel_q)
			lgst_pkg::SEL_FIRST: begin
				out_ch.next_row   = gen0_s2;
				out_ch.row_index  = idx0_s2;
				out_ch.frame_done = 1'b0;
			end
			lgst_pkg::SEL_MID: begin
				out_ch.next_row   = gen1_s2;
				out_ch.row_index  = idx0_s2 + RC'(1);
				out_ch.frame_done = 1'b0;
			end
			lgst_pkg::SEL_LAST: begin
				out_ch.next_row   = gen2_s2;
				out_ch.row_index  = '0;
				out_ch.frame_done = 1'b1;
			end
			default: begin
				out_ch.next_row   = gen0_s2;
				out_ch.row_index  = idx0_s2;
				out_ch.frame_done = 1'b0;
			end
		endcase
	end

	// The result pointer never runs past the end of its group.
	a_sel_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> sel_q <= last_sel_s2)
		else $error("result pointer beyond its group");

	// The end of a frame is always reported on row 0.
	a_done_on_row0: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.frame_done |-> out_ch.row_index == '0)
		else $error("frame end reported on a row other than 0");

	// The last row of a frame restarts the row count.
	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && is_last |=> row_counter_q == '0)
		else $error("row counter not restarted after the last row");

	// A row that produces no result leaves the result stage empty.
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s2_free && valid_s1 && kind_s1 == lgst_pkg::KIND_NONE |=> !valid_s2)
		else $error("result shown for a row that makes none");

endmodule

`default_nettype wire
